// ----- hdl/bbsd_pkg.sv -----
`default_nettype none

package bbsd_pkg;

  // Width of the binary input word.
  localparam int VALUE_W = 32;

  // Decimal digits needed to hold any 32-bit value (4294967295).
  localparam int FULL_DIGITS = 10;
  localparam int FULL_BCD_W  = 4 * FULL_DIGITS;

  // Digits shown on the outputs.
  localparam int MAX_DIGITS     = 8;
  localparam int DIGITS_DEFAULT = 8;

  // One shift-add-3 step per input bit.
  localparam int STEP_COUNT = VALUE_W;
  localparam int STEP_W     = $clog2(STEP_COUNT);

  localparam int SEG_W = 8;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_FINISH
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic step;
    logic capture;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last_step;
  } status_t;

  // Segment bits: A=0x80, B=0x40, C=0x20, D=0x10, F=0x08, G=0x04, E=0x02.
  function automatic logic [SEG_W-1:0] seg_pattern(input logic [3:0] digit);
    logic [SEG_W-1:0] pat;
    case (digit)
      4'd0:    pat = 8'hFA;
      4'd1:    pat = 8'h60;
      4'd2:    pat = 8'hD6;
      4'd3:    pat = 8'hF4;
      4'd4:    pat = 8'h6C;
      4'd5:    pat = 8'hBC;
      4'd6:    pat = 8'hBE;
      4'd7:    pat = 8'hE0;
      4'd8:    pat = 8'hFE;
      4'd9:    pat = 8'hFC;
      default: pat = 8'h00;
    endcase
    return pat;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/binary_to_bcd_seven_segment_core.sv -----
`default_nettype none

// Converts one 32-bit unsigned value per transaction into packed BCD and one
// seven-segment byte per digit. A transaction is taken at a rising edge where
// start is high and busy is low. The conversion is a shift-add-3 loop that
// consumes one input bit per cycle; after the last bit the finish state forms
// the segment bytes and registers them on the outputs together with the
// out_valid strobe. The result is marked by out_valid for a single cycle only
// and the receiver cannot stall it; the data ports keep the last result until
// the next one. busy drops in the cycle that out_valid is high, so a new
// transaction may be started then; a new transaction is never taken before
// the last one is through. Digits at or above DIGITS read as zero nibbles and
// blank segment bytes, and out_overflow is set when any dropped digit was
// nonzero. Leading zeros are not blanked.

module binary_to_bcd_seven_segment_core #(
  parameter int DIGITS = bbsd_pkg::DIGITS_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [31:0] in_value,
  output logic             out_valid,
  output logic [31:0]      out_bcd_digits,
  output logic [31:0]      out_segments_low,
  output logic [31:0]      out_segments_high,
  output logic             out_overflow
);

  bbsd_pkg::cmd_t    cmd;
  bbsd_pkg::status_t status;

  // The controller sequences load, the 32 conversion steps and capture.
  bbsd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .status    (status),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  // The datapath holds the shifting binary word, the BCD digits and the
  // output registers.
  bbsd_datapath #(
    .DIGITS (DIGITS)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .in_value          (in_value),
    .status            (status),
    .out_bcd_digits    (out_bcd_digits),
    .out_segments_low  (out_segments_low),
    .out_segments_high (out_segments_high),
    .out_overflow      (out_overflow)
  );

endmodule

`default_nettype wire

// ----- hdl/bbsd_ctrl.sv -----
`default_nettype none

module bbsd_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire bbsd_pkg::status_t status,
  output bbsd_pkg::cmd_t        cmd,
  output logic                  busy,
  output logic                  out_valid
);

  bbsd_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bbsd_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bbsd_pkg::ST_IDLE: begin
        if (start) state_nxt = bbsd_pkg::ST_CONV;
      end
      bbsd_pkg::ST_CONV: begin
        if (status.last_step) state_nxt = bbsd_pkg::ST_FINISH;
      end
      bbsd_pkg::ST_FINISH: begin
        state_nxt = bbsd_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = bbsd_pkg::ST_IDLE;
      end
    endcase
  end

  // Outputs.
  always_comb begin
    cmd           = '0;
    busy          = 1'b1;
    out_valid_nxt = 1'b0;
    case (state_r)
      bbsd_pkg::ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      bbsd_pkg::ST_CONV: begin
        cmd.step = 1'b1;
      end
      bbsd_pkg::ST_FINISH: begin
        cmd.capture   = 1'b1;
        out_valid_nxt = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// ----- hdl/bbsd_datapath.sv -----
`default_nettype none

module bbsd_datapath #(
  parameter int DIGITS = bbsd_pkg::DIGITS_DEFAULT
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire bbsd_pkg::cmd_t                cmd,
  input  wire logic [bbsd_pkg::VALUE_W-1:0]  in_value,
  output bbsd_pkg::status_t                  status,
  output logic [31:0]                        out_bcd_digits,
  output logic [31:0]                        out_segments_low,
  output logic [31:0]                        out_segments_high,
  output logic                               out_overflow
);

  localparam int BCD_W = bbsd_pkg::FULL_BCD_W;

  // DIGITS outside 1..8 is taken as the nearest legal count.
  localparam int SHOWN = (DIGITS < 1) ? 1 :
                         (DIGITS > bbsd_pkg::MAX_DIGITS) ? bbsd_pkg::MAX_DIGITS : DIGITS;

  logic [bbsd_pkg::VALUE_W-1:0] bin_r, bin_nxt;
  logic [BCD_W-1:0]             bcd_r, bcd_nxt;
  logic [bbsd_pkg::STEP_W-1:0]  count_r, count_nxt;
  logic [BCD_W-1:0]             bcd_adj;

  logic [31:0] bcd_out_nxt, seg_lo_nxt, seg_hi_nxt;
  logic        ovf_nxt;
  logic [31:0] bcd_out_r, seg_lo_r, seg_hi_r;
  logic        ovf_r;

  // Add 3 to every digit that is 5 or more before the shift doubles it.
  always_comb begin
    for (int i = 0; i < bbsd_pkg::FULL_DIGITS; i++) begin
      if (bcd_r[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd_r[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd_r[4*i +: 4];
      end
    end
  end

  always_comb begin
    bin_nxt   = bin_r;
    bcd_nxt   = bcd_r;
    count_nxt = count_r;
    if (cmd.load) begin
      bin_nxt   = in_value;
      bcd_nxt   = '0;
      count_nxt = '0;
    end else if (cmd.step) begin
      bin_nxt   = {bin_r[bbsd_pkg::VALUE_W-2:0], 1'b0};
      bcd_nxt   = {bcd_adj[BCD_W-2:0], bin_r[bbsd_pkg::VALUE_W-1]};
      count_nxt = count_r + bbsd_pkg::STEP_W'(1);
    end
  end

  assign status.last_step =
    (count_r == bbsd_pkg::STEP_W'(bbsd_pkg::STEP_COUNT - 1));

  // Shown digits, their segment bytes and the dropped-digit check.
  always_comb begin
    bcd_out_nxt = '0;
    seg_lo_nxt  = '0;
    seg_hi_nxt  = '0;
    ovf_nxt     = 1'b0;
    for (int i = 0; i < bbsd_pkg::MAX_DIGITS; i++) begin
      if (i < SHOWN) begin
        bcd_out_nxt[4*i +: 4] = bcd_r[4*i +: 4];
        if (i < 4) begin
          seg_lo_nxt[8*i +: 8] = bbsd_pkg::seg_pattern(bcd_r[4*i +: 4]);
        end else begin
          seg_hi_nxt[8*(i-4) +: 8] = bbsd_pkg::seg_pattern(bcd_r[4*i +: 4]);
        end
      end
    end
    for (int i = 0; i < bbsd_pkg::FULL_DIGITS; i++) begin
      if (i >= SHOWN && bcd_r[4*i +: 4] != 4'd0) begin
        ovf_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
    if (cmd.capture) begin
      bcd_out_r <= bcd_out_nxt;
      seg_lo_r  <= seg_lo_nxt;
      seg_hi_r  <= seg_hi_nxt;
      ovf_r     <= ovf_nxt;
    end
  end

  assign out_bcd_digits    = bcd_out_r;
  assign out_segments_low  = seg_lo_r;
  assign out_segments_high = seg_hi_r;
  assign out_overflow      = ovf_r;

endmodule

`default_nettype wire

// ----- hdl/bbsd_checker.sv -----
`default_nettype none

module bbsd_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        out_valid,
  input wire logic [31:0] out_bcd_digits,
  input wire logic [31:0] out_segments_low,
  input wire logic [31:0] out_segments_high,
  input wire logic        out_overflow
);

  // A result is only shown once the block is free again.
  a_valid_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while busy");

  // An accepted transaction keeps the block busy and gives no result at once.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy && !out_valid))
    else $error("accepted transaction did not start a conversion");

  // Each finished conversion, marked by busy falling, gives a result strobe.
  a_done_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    ($fell(busy) && $past(rst_n)) |-> out_valid)
    else $error("conversion ended without a result");

  // The result strobe lasts one cycle.
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  // A shown result carries no unknown bits.
  a_result_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !$isunknown({out_bcd_digits, out_segments_low,
                               out_segments_high, out_overflow}))
    else $error("result has unknown bits");

endmodule

bind binary_to_bcd_seven_segment_core bbsd_checker u_bbsd_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .start             (start),
  .busy              (busy),
  .out_valid         (out_valid),
  .out_bcd_digits    (out_bcd_digits),
  .out_segments_low  (out_segments_low),
  .out_segments_high (out_segments_high),
  .out_overflow      (out_overflow)
);

`default_nettype wire
